// ===== rtl/core/staggered_valve_pump_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the valve/pump scheduler
// Shared concurrent check forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef STAGGERED_VALVE_PUMP_SCHEDULER_ASSERT_SVH
`define STAGGERED_VALVE_PUMP_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define SVPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svps check failed");

// next-cycle implication
`define SVPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svps check failed");

`endif

// ===== rtl/core/svps_pkg.sv =====
// ----------------------------------------------------------------------------
// svps_pkg
// Types, codes and fixed tables of the valve/pump relay scheduler.
// ----------------------------------------------------------------------------
package svps_pkg;

    localparam int RELAY_W    = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_MANUAL = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;
    localparam logic [1:0] KIND_RESUME = 2'd3;

    // run modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ROUND1 = 2'd1;
    localparam logic [1:0] MODE_ROUND2 = 2'd2;
    localparam logic [1:0] MODE_MANUAL = 2'd3;

    // board roles
    localparam logic [2:0] ROLE_MASTER      = 3'd0;
    localparam logic [2:0] ROLE_PUMP_DUTY   = 3'd1;
    localparam logic [2:0] ROLE_PUMP_SOLAR  = 3'd2;
    localparam logic [2:0] ROLE_PUMP_VALVES = 3'd3;

    // config register indexes
    localparam logic [2:0] CFG_BOARD_ROLE   = 3'd0;
    localparam logic [2:0] CFG_R1_START     = 3'd1;
    localparam logic [2:0] CFG_R1_LENGTH    = 3'd2;
    localparam logic [2:0] CFG_R2_START     = 3'd3;
    localparam logic [2:0] CFG_R2_LENGTH    = 3'd4;
    localparam logic [2:0] CFG_PUMP_OPEN    = 3'd5;
    localparam logic [2:0] CFG_PUMP_CLOSE   = 3'd6;
    localparam logic [2:0] CFG_SOLAR_CLOSE  = 3'd7;

    // config reset values
    localparam logic [10:0] PUMP_OPEN_RST   = 11'd540;
    localparam logic [10:0] PUMP_CLOSE_RST  = 11'd1020;
    localparam logic [10:0] SOLAR_CLOSE_RST = 11'd830;

    // valve slice of each board: first global valve minus one, and count
    localparam logic [4:0] SLICE_BASE [8] = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd10, 5'd14};
    localparam logic [2:0] SLICE_SIZE [8] = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd4, 3'd6, 3'd4, 3'd6};

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] minute_of_day;
        logic [31:0] now_ms;
        logic        solar_good;
        logic [7:0]  manual_valve;
        logic [15:0] manual_minutes;
    } in_item_t;

    typedef struct packed {
        logic [5:0] relay_mask;
        logic       relays_written;
        logic [1:0] run_mode;
        logic [4:0] last_valve;
        logic       halted;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  board_role;
        logic [10:0] round1_start;
        logic [7:0]  round1_length;
        logic [10:0] round2_start;
        logic [7:0]  round2_length;
        logic [10:0] pump_window_open;
        logic [10:0] pump_window_close;
        logic [10:0] solar_pump_close;
    } cfg_t;

    typedef struct packed {
        logic        stop_latch;
        logic        manual_on;
        logic [7:0]  manual_target;
        logic [31:0] manual_deadline;
        logic [1:0]  mode;
        logic [4:0]  last_valve;
        logic [5:0]  relay;
    } sched_state_t;

    // relays that exist on a board with n local relays
    function automatic logic [RELAY_W-1:0] relay_keep(input int n);
        logic [RELAY_W-1:0] k;
        k = '0;
        for (int i = 0; i < RELAY_W; i++)
        begin
            k[i] = (i < n);
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/svps_cfg.sv =====
// ----------------------------------------------------------------------------
// svps_cfg
// Configuration register file, written through a plain enable/index/data port.
// ----------------------------------------------------------------------------
module svps_cfg
    import svps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_role        <= '0;
            cfg_reg.round1_start      <= '0;
            cfg_reg.round1_length     <= '0;
            cfg_reg.round2_start      <= '0;
            cfg_reg.round2_length     <= '0;
            cfg_reg.pump_window_open  <= PUMP_OPEN_RST;
            cfg_reg.pump_window_close <= PUMP_CLOSE_RST;
            cfg_reg.solar_pump_close  <= SOLAR_CLOSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOARD_ROLE:  cfg_reg.board_role        <= cfg_data[2:0];
                CFG_R1_START:    cfg_reg.round1_start      <= cfg_data;
                CFG_R1_LENGTH:   cfg_reg.round1_length     <= cfg_data[7:0];
                CFG_R2_START:    cfg_reg.round2_start      <= cfg_data;
                CFG_R2_LENGTH:   cfg_reg.round2_length     <= cfg_data[7:0];
                CFG_PUMP_OPEN:   cfg_reg.pump_window_open  <= cfg_data;
                CFG_PUMP_CLOSE:  cfg_reg.pump_window_close <= cfg_data;
                CFG_SOLAR_CLOSE: cfg_reg.solar_pump_close  <= cfg_data;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/svps_eval.sv =====
// ----------------------------------------------------------------------------
// svps_eval
// Single-pass evaluation of one beat: schedule windows, pump duty cycle,
// manual override and stop latch, giving the next state and the result.
// ----------------------------------------------------------------------------
module svps_eval
    import svps_pkg::*;
#(
    parameter int PUMP_ON_MINUTES  = 50,
    parameter int PUMP_OFF_MINUTES = 10,
    parameter int VALVE_COUNT      = 20,
    parameter int LOCAL_RELAYS     = 6
)
(
    input  cfg_t         cfg,
    input  sched_state_t state,
    input  in_item_t     item,
    output sched_state_t state_next,
    output out_item_t    result
);

    localparam int PERIOD = PUMP_ON_MINUTES + PUMP_OFF_MINUTES;
    // floor(2^16 / period): quotient estimate is low by at most one for 11-bit values
    localparam int RECIP  = 65536 / PERIOD;
    localparam logic [20:0] PERIOD_W = 21'(PERIOD);
    localparam logic [11:0] PERIOD_R = 12'(PERIOD);
    localparam logic [11:0] ON_R     = 12'(PUMP_ON_MINUTES);
    localparam logic [27:0] RECIP_W  = 28'(RECIP);
    localparam logic [5:0]  VALVES_W = 6'(VALVE_COUNT);
    localparam logic [RELAY_W-1:0] KEEP = relay_keep(LOCAL_RELAYS);

    // staggered window of valve idx (0-based) in a round
    function automatic logic win_open(input logic [10:0] now, input logic [10:0] start,
                                      input logic [7:0] len, input logic [4:0] idx);
        logic [7:0]  step;
        logic [13:0] s;
        logic [13:0] e;
        step = (len > 8'd1) ? len - 8'd1 : 8'd1;
        s    = 14'(start) + 14'(idx) * 14'(step);
        e    = s + 14'(len);
        return (14'(now) >= s) && (14'(now) < e);
    endfunction

    // duty cycle inside [start, stop): on for the first minutes of each period
    function automatic logic duty_on(input logic [10:0] now, input logic [10:0] start,
                                     input logic [10:0] stop);
        logic [10:0] d;
        logic [27:0] prod;
        logic [10:0] q;
        logic [11:0] r;
        d    = now - start;
        prod = 28'(d) * RECIP_W;
        q    = prod[26:16];
        r    = 12'(21'(d) - 21'(q) * PERIOD_W);
        if (r >= PERIOD_R)
        begin
            r = r - PERIOD_R;
        end
        return (now >= start) && (now < stop) && (r < ON_R);
    endfunction

    logic [2:0]  role;
    logic [4:0]  base;
    logic [2:0]  size;
    logic        duty1;
    logic        duty2;
    logic        any_win;
    logic [5:0]  man_mask;
    logic [8:0]  man_off;
    logic        man_hit;
    logic [5:0]  slice_mask;
    logic        hit1;
    logic        hit2;
    logic [4:0]  last1;
    logic [4:0]  last2;
    logic [5:0]  valve;
    logic        member;
    logic        open1;
    logic        open2;
    logic [5:0]  mask;
    logic [1:0]  mode;
    logic [31:0] man_span;

    assign role = cfg.board_role;
    assign base = SLICE_BASE[role];
    assign size = SLICE_SIZE[role];

    // pump windows
    assign duty1 = duty_on(item.minute_of_day, cfg.pump_window_open, cfg.pump_window_close);
    assign duty2 = duty_on(item.minute_of_day, cfg.round1_start, cfg.solar_pump_close);

    // any valve window open, either round (board 3 pump)
    always_comb
    begin
        any_win = 1'b0;
        for (int i = 0; i < VALVE_COUNT; i++)
        begin
            if (cfg.round1_length != 8'd0 &&
                win_open(item.minute_of_day, cfg.round1_start, cfg.round1_length, 5'(i)))
            begin
                any_win = 1'b1;
            end
            if (cfg.round2_length != 8'd0 &&
                win_open(item.minute_of_day, cfg.round2_start, cfg.round2_length, 5'(i)))
            begin
                any_win = 1'b1;
            end
        end
    end

    // manual target on this board's slice
    always_comb
    begin
        man_off  = 9'(state.manual_target) - 9'(base) - 9'd1;
        man_hit  = (9'(state.manual_target) > 9'(base)) &&
                   (9'(state.manual_target) <= 9'(base) + 9'(size));
        man_mask = '0;
        for (int j = 0; j < RELAY_W; j++)
        begin
            man_mask[j] = man_hit && (man_off == 9'(j));
        end
    end

    // valves of the own slice; later hits win for last valve
    always_comb
    begin
        slice_mask = '0;
        hit1       = 1'b0;
        hit2       = 1'b0;
        last1      = '0;
        last2      = '0;
        valve      = '0;
        member     = 1'b0;
        open1      = 1'b0;
        open2      = 1'b0;
        for (int j = 0; j < RELAY_W; j++)
        begin
            valve  = 6'(base) + 6'(j) + 6'd1;
            member = (3'(j) < size) && (valve <= VALVES_W);
            open1  = member && (cfg.round1_length != 8'd0) &&
                     win_open(item.minute_of_day, cfg.round1_start, cfg.round1_length,
                              5'(valve - 6'd1));
            open2  = member && (cfg.round2_length != 8'd0) &&
                     win_open(item.minute_of_day, cfg.round2_start, cfg.round2_length,
                              5'(valve - 6'd1));
            slice_mask[j] = open1 || open2;
            if (open1)
            begin
                hit1  = 1'b1;
                last1 = valve[4:0];
            end
            if (open2)
            begin
                hit2  = 1'b1;
                last2 = valve[4:0];
            end
        end
    end

    assign man_span = 32'(item.manual_minutes) * MS_PER_MINUTE;

    // state update and result
    always_comb
    begin
        state_next            = state;
        result.relays_written = 1'b0;
        mask                  = '0;
        mode                  = MODE_IDLE;
        case (item.kind)
            KIND_MANUAL:
            begin
                state_next.manual_target   = item.manual_valve;
                state_next.manual_deadline = item.now_ms + man_span;
                state_next.manual_on       = (item.manual_minutes != 16'd0);
            end
            KIND_STOP:
            begin
                state_next.stop_latch = 1'b1;
                state_next.manual_on  = 1'b0;
                state_next.mode       = MODE_IDLE;
                state_next.relay      = '0;
                result.relays_written = 1'b1;
            end
            KIND_RESUME:
            begin
                state_next.stop_latch = 1'b0;
            end
            default:
            begin
                if (role != ROLE_MASTER && !state.stop_latch)
                begin
                    if (state.manual_on)
                    begin
                        if (item.now_ms > state.manual_deadline)
                        begin
                            state_next.manual_on = 1'b0;
                        end
                        else
                        begin
                            mode = MODE_MANUAL;
                            if (role == ROLE_PUMP_VALVES)
                            begin
                                mask[0] = 1'b1;
                            end
                            else if (role inside {[3'd4:3'd7]})
                            begin
                                mask = man_mask;
                            end
                        end
                    end
                    else
                    begin
                        case (role)
                            ROLE_PUMP_DUTY:
                            begin
                                if (duty1)
                                begin
                                    mask[0] = 1'b1;
                                    mode    = MODE_ROUND1;
                                end
                            end
                            ROLE_PUMP_SOLAR:
                            begin
                                if (item.solar_good && duty2)
                                begin
                                    mask[0] = 1'b1;
                                    mode    = MODE_ROUND1;
                                end
                            end
                            ROLE_PUMP_VALVES:
                            begin
                                if (item.solar_good && any_win)
                                begin
                                    mask[0] = 1'b1;
                                    mode    = MODE_ROUND1;
                                end
                            end
                            default:
                            begin
                                mask = slice_mask;
                                if (hit1)
                                begin
                                    mode = MODE_ROUND1;
                                end
                                else if (hit2)
                                begin
                                    mode = MODE_ROUND2;
                                end
                                if (hit2)
                                begin
                                    state_next.last_valve = last2;
                                end
                                else if (hit1)
                                begin
                                    state_next.last_valve = last1;
                                end
                            end
                        endcase
                    end
                    state_next.mode       = mode;
                    state_next.relay      = mask & KEEP;
                    result.relays_written = 1'b1;
                end
            end
        endcase
        result.relay_mask = state_next.relay;
        result.run_mode   = state_next.mode;
        result.last_valve = state_next.last_valve;
        result.halted     = state_next.stop_latch;
    end

endmodule

// ===== rtl/core/staggered_valve_pump_scheduler.sv =====
// ----------------------------------------------------------------------------
// staggered_valve_pump_scheduler: relay scheduler for one irrigation board
// A beat accepted into the input register shows at out_data once its result is
// loaded into the result register. Throughput: one beat per cycle unless out_ready
// stalls it, set by the single evaluation pass between input and result registers.
// Reset clears all state, loads config defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
module staggered_valve_pump_scheduler
    import svps_pkg::*;
#(
    parameter int PUMP_ON_MINUTES  = 50,
    parameter int PUMP_OFF_MINUTES = 10,
    parameter int VALVE_COUNT      = 20,
    parameter int LOCAL_RELAYS     = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "staggered_valve_pump_scheduler_assert.svh"

    localparam logic [RELAY_W-1:0] KEEP = relay_keep(LOCAL_RELAYS);

    cfg_t         cfg;
    sched_state_t state_reg;
    sched_state_t state_next;
    out_item_t    result;
    logic         s1_valid_reg;
    in_item_t     s1_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    logic         s1_advance;

    svps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svps_eval #(
        .PUMP_ON_MINUTES  (PUMP_ON_MINUTES),
        .PUMP_OFF_MINUTES (PUMP_OFF_MINUTES),
        .VALVE_COUNT      (VALVE_COUNT),
        .LOCAL_RELAYS     (LOCAL_RELAYS)
    ) u_eval
    (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // handshake: input stage moves when the result slot is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    // control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_item_reg <= result;
        end
    end

    // checks
    `SVPS_ASSERT_IMP(a_halt_relays_off, out_valid_reg && out_item_reg.halted,
        out_item_reg.relay_mask == '0 && out_item_reg.run_mode == MODE_IDLE)
    `SVPS_ASSERT_IMP(a_no_accept_when_full, s1_valid_reg && out_valid_reg && !out_ready,
        !in_ready)
    `SVPS_ASSERT_NXT(a_advance_fills_out, s1_advance, out_valid_reg)
    `SVPS_ASSERT_IMP(a_relays_in_range, out_valid_reg,
        (out_item_reg.relay_mask & ~KEEP) == '0)

endmodule

// ===== sim/tb_staggered_valve_pump_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_staggered_valve_pump_scheduler: self-checking bench for the relay scheduler
// Drives tick, manual, stop and resume beats through the valid/ready input,
// predicts every result beat from a behavioral model of the board roles and
// compares each output beat field by field. Walks the block through all board
// roles and a range of schedule settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_staggered_valve_pump_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import svps_pkg::*;

    localparam int DUTY_ON_MIN  = 50;
    localparam int DUTY_PERIOD  = 60;
    localparam int VALVE_TOTAL  = 20;
    localparam int CYCLE_LIMIT  = 800000;
    localparam logic [2:0] ROLE_LAST = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block's registers and state
    cfg_t         cfg_shadow;
    sched_state_t sched;
    out_item_t    expected_q[$];
    out_item_t    want;
    int           fail_count;
    bit           steady;
    logic [31:0]  sim_ms;

    staggered_valve_pump_scheduler uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // local relay of a global valve on this board, -1 if foreign
    function automatic int valve_slot(input int valve);
        int role;
        int base;
        role = cfg_shadow.board_role;
        base = int'(SLICE_BASE[role]);
        if (role == ROLE_MASTER)
            return -1;
        if (valve > base && valve <= base + int'(SLICE_SIZE[role]))
            return valve - base - 1;
        return -1;
    endfunction

    // staggered window of valve idx+1 in a round
    function automatic bit window_hit(input int now, input int start, input int len,
                                      input int idx);
        int step;
        int first;
        step  = (len > 1) ? len - 1 : 1;
        first = start + idx * step;
        return (now >= first) && (now < first + len);
    endfunction

    // pump duty cycle inside [start, stop)
    function automatic bit duty_hit(input int now, input int start, input int stop);
        if (now < start || now >= stop)
            return 1'b0;
        return ((now - start) % DUTY_PERIOD) < DUTY_ON_MIN;
    endfunction

    // local relays opened by one round; records the last local valve hit
    function automatic logic [RELAY_W-1:0] scan_round(input int now, input int start,
                                                      input int len);
        logic [RELAY_W-1:0] hits;
        int slot;
        hits = '0;
        if (len == 0)
            return hits;
        for (int i = 0; i < VALVE_TOTAL; i++)
        begin
            if (window_hit(now, start, len, i))
            begin
                slot = valve_slot(i + 1);
                if (slot >= 0)
                begin
                    hits[slot] = 1'b1;
                    sched.last_valve = 5'(i + 1);
                end
            end
        end
        return hits;
    endfunction

    // next state and result beat for one accepted input beat
    function automatic out_item_t relay_outcome(input in_item_t it);
        out_item_t          res;
        logic [RELAY_W-1:0] mask;
        logic [RELAY_W-1:0] r1;
        logic [RELAY_W-1:0] r2;
        logic [1:0]         mode;
        logic [2:0]         role;
        logic               written;
        bit                 any;
        int                 now;
        int                 slot;
        written = 1'b0;
        role    = cfg_shadow.board_role;
        now     = it.minute_of_day;
        case (it.kind)
            KIND_MANUAL:
            begin
                sched.manual_target   = it.manual_valve;
                sched.manual_deadline = it.now_ms + 32'(it.manual_minutes) * MS_PER_MINUTE;
                sched.manual_on       = (it.manual_minutes != 16'd0);
            end
            KIND_STOP:
            begin
                sched.stop_latch = 1'b1;
                sched.manual_on  = 1'b0;
                sched.mode       = MODE_IDLE;
                sched.relay      = '0;
                written          = 1'b1;
            end
            KIND_RESUME:
            begin
                sched.stop_latch = 1'b0;
            end
            KIND_TICK:
            begin
                if (role != ROLE_MASTER && !sched.stop_latch)
                begin
                    mask = '0;
                    mode = MODE_IDLE;
                    if (sched.manual_on)
                    begin
                        // deadline compare is plain unsigned, no wrap handling
                        if (it.now_ms > sched.manual_deadline)
                            sched.manual_on = 1'b0;
                        else
                        begin
                            mode = MODE_MANUAL;
                            if (role == ROLE_PUMP_VALVES)
                                mask[0] = 1'b1;
                            else if (role > ROLE_PUMP_VALVES)
                            begin
                                slot = valve_slot(sched.manual_target);
                                if (slot >= 0)
                                    mask[slot] = 1'b1;
                            end
                        end
                    end
                    else if (role == ROLE_PUMP_DUTY)
                    begin
                        if (duty_hit(now, cfg_shadow.pump_window_open,
                                     cfg_shadow.pump_window_close))
                        begin
                            mask[0] = 1'b1;
                            mode    = MODE_ROUND1;
                        end
                    end
                    else if (role == ROLE_PUMP_SOLAR)
                    begin
                        if (it.solar_good && duty_hit(now, cfg_shadow.round1_start,
                                                      cfg_shadow.solar_pump_close))
                        begin
                            mask[0] = 1'b1;
                            mode    = MODE_ROUND1;
                        end
                    end
                    else if (role == ROLE_PUMP_VALVES)
                    begin
                        any = 1'b0;
                        for (int i = 0; i < VALVE_TOTAL; i++)
                        begin
                            if (cfg_shadow.round1_length != 0 &&
                                window_hit(now, cfg_shadow.round1_start,
                                           cfg_shadow.round1_length, i))
                                any = 1'b1;
                            if (cfg_shadow.round2_length != 0 &&
                                window_hit(now, cfg_shadow.round2_start,
                                           cfg_shadow.round2_length, i))
                                any = 1'b1;
                        end
                        if (any && it.solar_good)
                        begin
                            mask[0] = 1'b1;
                            mode    = MODE_ROUND1;
                        end
                    end
                    else
                    begin
                        r1   = scan_round(now, cfg_shadow.round1_start, cfg_shadow.round1_length);
                        r2   = scan_round(now, cfg_shadow.round2_start, cfg_shadow.round2_length);
                        mask = r1 | r2;
                        if (r1 != '0)
                            mode = MODE_ROUND1;
                        else if (r2 != '0)
                            mode = MODE_ROUND2;
                    end
                    sched.mode  = mode;
                    sched.relay = mask;
                    written     = 1'b1;
                end
            end
        endcase
        res.relay_mask     = sched.relay;
        res.relays_written = written;
        res.run_mode       = sched.mode;
        res.last_valve     = sched.last_valve;
        res.halted         = sched.stop_latch;
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // minute of day biased toward window edges
    function automatic int pick_minute();
        int m;
        case ($urandom_range(0, 3))
            0: m = $urandom_range(0, 1439);
            1: m = int'(cfg_shadow.round1_start) +
                   int'($urandom_range(0, VALVE_TOTAL * (cfg_shadow.round1_length + 1)));
            2: m = int'(cfg_shadow.round2_start) +
                   int'($urandom_range(0, VALVE_TOTAL * (cfg_shadow.round2_length + 1)));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: m = cfg_shadow.pump_window_open;
                    1: m = cfg_shadow.pump_window_close;
                    2: m = cfg_shadow.solar_pump_close;
                    default: m = cfg_shadow.round1_start;
                endcase
                m = m + int'($urandom_range(0, 8)) - 4;
            end
        endcase
        if (m < 0)
            m = m + 1440;
        return m % 1440;
    endfunction

    function automatic logic [10:0] pick_start();
        case ($urandom_range(0, 3))
            0: return 11'd0;
            1: return 11'd1439;
            default: return 11'($urandom_range(0, 1439));
        endcase
    endfunction

    function automatic logic [7:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(2, 40));
        endcase
    endfunction

    // window end: extremes, empty window, or random
    function automatic logic [10:0] pick_close(input logic [10:0] open_min);
        case ($urandom_range(0, 4))
            0: return 11'd0;
            1: return 11'd1440;
            2: return open_min;
            default: return 11'($urandom_range(0, 1440));
        endcase
    endfunction

    function automatic cfg_t random_cfg(input logic [2:0] role);
        cfg_t c;
        c.board_role        = role;
        c.round1_start      = pick_start();
        c.round1_length     = pick_len();
        c.round2_start      = pick_start();
        c.round2_length     = pick_len();
        c.pump_window_open  = pick_start();
        c.pump_window_close = pick_close(c.pump_window_open);
        c.solar_pump_close  = pick_close(c.round1_start);
        return c;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] kind, input int minute,
                                           input logic [31:0] ms, input bit solar,
                                           input int valve, input int minutes);
        in_item_t it;
        it.kind           = kind;
        it.minute_of_day  = 11'(minute);
        it.now_ms         = ms;
        it.solar_good     = solar;
        it.manual_valve   = 8'(valve);
        it.manual_minutes = 16'(minutes);
        return it;
    endfunction

    // random beat; the millisecond clock mostly runs forward so manual runs expire
    function automatic in_item_t random_beat(input int tick_pct, input int manual_pct,
                                             input int stop_pct);
        in_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            it.kind = KIND_TICK;
        else if (r < tick_pct + manual_pct)
            it.kind = KIND_MANUAL;
        else if (r < tick_pct + manual_pct + stop_pct)
            it.kind = KIND_STOP;
        else
            it.kind = KIND_RESUME;
        if ($urandom_range(0, 19) == 0)
            sim_ms = $urandom();
        else
            sim_ms = sim_ms + $urandom_range(0, 90000);
        it.minute_of_day = 11'(pick_minute());
        it.now_ms        = sim_ms;
        it.solar_good    = ($urandom_range(0, 3) != 0);
        it.manual_valve  = ($urandom_range(0, 5) == 0) ? 8'($urandom())
                                                       : 8'($urandom_range(1, VALVE_TOTAL));
        case ($urandom_range(0, 7))
            0: it.manual_minutes = 16'($urandom_range(0, 65535));
            1: it.manual_minutes = 16'd0;
            default: it.manual_minutes = 16'($urandom_range(1, 3));
        endcase
        return it;
    endfunction

    // one input beat: optional gap, then hold valid until accepted
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(relay_outcome(it));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // write all eight registers back to back while the block is idle
    task automatic load_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[CFG_BOARD_ROLE]  = CFG_DATA_W'(c.board_role);
        vals[CFG_R1_START]    = c.round1_start;
        vals[CFG_R1_LENGTH]   = CFG_DATA_W'(c.round1_length);
        vals[CFG_R2_START]    = c.round2_start;
        vals[CFG_R2_LENGTH]   = CFG_DATA_W'(c.round2_length);
        vals[CFG_PUMP_OPEN]   = c.pump_window_open;
        vals[CFG_PUMP_CLOSE]  = c.pump_window_close;
        vals[CFG_SOLAR_CLOSE] = c.solar_pump_close;
        wait_drain();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_shadow = c;
    endtask

    task automatic run_beats(input int count, input int tick_pct, input int manual_pct,
                             input int stop_pct);
        steady = ($urandom_range(0, 3) == 0);
        repeat (count) send_beat(random_beat(tick_pct, manual_pct, stop_pct));
    endtask

    // master role, both windows, manual edge cases, stop/resume
    task automatic test_directed();
        cfg_t c;
        // master board after reset never drives
        send_beat(make_item(KIND_TICK, 600, 32'd0, 1'b1, 0, 0));
        send_beat(make_item(KIND_MANUAL, 0, 32'd0, 1'b0, 5, 3));
        send_beat(make_item(KIND_TICK, 600, 32'd10, 1'b1, 0, 0));
        send_beat(make_item(KIND_STOP, 0, 32'd0, 1'b0, 0, 0));
        send_beat(make_item(KIND_RESUME, 0, 32'd0, 1'b0, 0, 0));
        // board 5 (valves 5..10), one-minute round 1 and a full-length round 2
        c.board_role        = ROLE_PUMP_VALVES + 3'd2;
        c.round1_start      = 11'd0;
        c.round1_length     = 8'd1;
        c.round2_start      = 11'd1439;
        c.round2_length     = 8'd255;
        c.pump_window_open  = 11'd0;
        c.pump_window_close = 11'd1440;
        c.solar_pump_close  = 11'd1440;
        load_config(c);
        send_beat(make_item(KIND_TICK, 4, 32'd100, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 1439, 32'd100, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 9, 32'd100, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 0, 32'd100, 1'b0, 0, 0));
        // deadline wraps past 2^32, so the next tick ends manual at once
        send_beat(make_item(KIND_MANUAL, 0, 32'hFFFF_FFF0, 1'b0, 7, 65535));
        send_beat(make_item(KIND_TICK, 4, 32'hFFFF_FFFF, 1'b0, 0, 0));
        // manual holds at the deadline and ends one ms later
        send_beat(make_item(KIND_MANUAL, 0, 32'd1000, 1'b0, 7, 1));
        send_beat(make_item(KIND_TICK, 4, 32'd61000, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 4, 32'd61001, 1'b0, 0, 0));
        // foreign valve, then cancel by zero minutes
        send_beat(make_item(KIND_MANUAL, 0, 32'd0, 1'b0, 255, 10));
        send_beat(make_item(KIND_TICK, 4, 32'd5, 1'b0, 0, 0));
        send_beat(make_item(KIND_MANUAL, 0, 32'd0, 1'b0, 6, 0));
        send_beat(make_item(KIND_TICK, 4, 32'd10, 1'b0, 0, 0));
        // stop latches off; manual still taken while halted
        send_beat(make_item(KIND_STOP, 0, 32'd0, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 4, 32'd20, 1'b1, 0, 0));
        send_beat(make_item(KIND_MANUAL, 0, 32'd0, 1'b0, 6, 2));
        send_beat(make_item(KIND_RESUME, 0, 32'd0, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 4, 32'd100, 1'b0, 0, 0));
        send_beat(make_item(KIND_TICK, 1439, 32'hFFFF_FFFF, 1'b1, 255, 65535));
    endtask

    task automatic test_master_role();
        load_config(random_cfg(ROLE_MASTER));
        run_beats(60, 70, 15, 5);
    endtask

    task automatic test_pump_duty();
        cfg_t c;
        for (int p = 0; p < 3; p++)
        begin
            c = random_cfg(ROLE_PUMP_DUTY);
            if (p == 0)
            begin
                c.pump_window_open  = 11'd0;
                c.pump_window_close = 11'd1440;
            end
            else if (p == 1)
            begin
                // empty window
                c.pump_window_open  = 11'd1439;
                c.pump_window_close = 11'($urandom_range(0, 1439));
            end
            load_config(c);
            run_beats(80, 90, 4, 3);
        end
    endtask

    task automatic test_solar_pump();
        cfg_t c;
        for (int p = 0; p < 3; p++)
        begin
            c = random_cfg(ROLE_PUMP_SOLAR);
            if (p == 0)
            begin
                c.round1_start     = 11'd0;
                c.solar_pump_close = 11'd1440;
            end
            else if (p == 1)
            begin
                c.round1_start     = 11'd1439;
                c.solar_pump_close = 11'd1440;
            end
            load_config(c);
            run_beats(80, 90, 4, 3);
        end
    endtask

    task automatic test_valve_pump();
        cfg_t c;
        for (int p = 0; p < 3; p++)
        begin
            c = random_cfg(ROLE_PUMP_VALVES);
            if (p == 0)
            begin
                c.round1_start  = 11'd0;
                c.round1_length = 8'd1;
                c.round2_start  = 11'd1439;
                c.round2_length = 8'd255;
            end
            else if (p == 1)
            begin
                // both rounds disabled
                c.round1_length = 8'd0;
                c.round2_length = 8'd0;
            end
            load_config(c);
            run_beats(80, 90, 4, 3);
        end
    endtask

    task automatic test_valve_slices();
        cfg_t c;
        for (int role = ROLE_PUMP_VALVES + 1; role <= ROLE_LAST; role++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                c = random_cfg(3'(role));
                if (p == 0)
                begin
                    c.round1_length = 8'($urandom_range(1, 12));
                    c.round2_length = 8'($urandom_range(1, 12));
                end
                load_config(c);
                run_beats(60, 88, 6, 3);
            end
        end
    endtask

    task automatic test_manual_override();
        for (int p = 0; p < 2; p++)
        begin
            load_config(random_cfg((p == 0) ? ROLE_PUMP_VALVES
                                            : 3'($urandom_range(1, ROLE_LAST))));
            run_beats(80, 55, 35, 4);
        end
    endtask

    task automatic test_stop_resume();
        load_config(random_cfg(3'($urandom_range(1, ROLE_LAST))));
        run_beats(100, 50, 15, 17);
    endtask

    task automatic test_random_mix();
        repeat (5)
        begin
            load_config(random_cfg(3'($urandom_range(0, ROLE_LAST))));
            run_beats(80, 75, 12, 5);
        end
    endtask

    // result side: ready with random stalls
    initial
    begin
        int hold;
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: %0h", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.relay_mask !== want.relay_mask)
                begin
                    $error("relay_mask: expected %0h, got %0h",
                           want.relay_mask, out_data.relay_mask);
                    fail_count++;
                end
                if (out_data.relays_written !== want.relays_written)
                begin
                    $error("relays_written: expected %0d, got %0d",
                           want.relays_written, out_data.relays_written);
                    fail_count++;
                end
                if (out_data.run_mode !== want.run_mode)
                begin
                    $error("run_mode: expected %0d, got %0d",
                           want.run_mode, out_data.run_mode);
                    fail_count++;
                end
                if (out_data.last_valve !== want.last_valve)
                begin
                    $error("last_valve: expected %0d, got %0d",
                           want.last_valve, out_data.last_valve);
                    fail_count++;
                end
                if (out_data.halted !== want.halted)
                begin
                    $error("halted: expected %0d, got %0d",
                           want.halted, out_data.halted);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        fail_count = 0;
        steady     = 1'b0;
        sim_ms     = $urandom();
        sched      = '0;
        cfg_shadow = '0;
        cfg_shadow.pump_window_open  = PUMP_OPEN_RST;
        cfg_shadow.pump_window_close = PUMP_CLOSE_RST;
        cfg_shadow.solar_pump_close  = SOLAR_CLOSE_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_master_role();
        test_pump_duty();
        test_solar_pump();
        test_valve_pump();
        test_valve_slices();
        test_manual_override();
        test_stop_resume();
        test_random_mix();

        wait_drain();
        repeat (4) @(posedge clk);
        if (expected_q.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
